FILE: rtl/mips_decode_execute_defines.svh
// Assertion macros shared by the decode and execute RTL.
`ifndef MIPS_DECODE_EXECUTE_DEFINES_SVH
`define MIPS_DECODE_EXECUTE_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check, held off while reset is asserted.
`define MDX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MDX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MDX_ASSERT(lbl, clk, rst_n, prop, msg)

`define MDX_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/mdx_pkg.sv
// Opcodes, function codes and shared types of the decode and execute stage.
`default_nettype none

package mdx_pkg;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0a;
    localparam logic [5:0] OP_SLTIU = 6'h0b;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [4:0] LINK_REG = 5'd31;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOR,
        ALU_SLT,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_LUI,
        ALU_LINK
    } alu_op_t;

    typedef enum logic [1:0] {
        OPB_REG,
        OPB_SIMM,
        OPB_ZIMM
    } opb_sel_t;

    typedef struct packed {
        alu_op_t    alu_op;
        opb_sel_t   opb_sel;
        logic       reg_write;
        logic [4:0] dest_reg;
        logic       mem_read;
        logic       mem_write;
        logic       branch_eq;
        logic       branch_ne;
        logic       jump_abs;
        logic       jump_reg;
    } ctrl_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc_plus4;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] alu_result;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] store_data;
        logic        redirect;
        logic [31:0] redirect_target;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/mdx_in_if.sv
// Instruction channel: valid/ready handshake with the instruction and its operands.
`default_nettype none

interface mdx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] pc_plus4;
    logic [31:0] rs_value;
    logic [31:0] rt_value;

    modport source (
        output valid, instruction, pc_plus4, rs_value, rt_value,
        input  ready
    );

    modport sink (
        input  valid, instruction, pc_plus4, rs_value, rt_value,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/mdx_out_if.sv
// Result channel: valid/ready handshake with the execute results.
`default_nettype none

interface mdx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] alu_result;
    logic [4:0]  dest_reg;
    logic        reg_write;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] store_data;
    logic        redirect;
    logic [31:0] redirect_target;

    modport source (
        output valid, alu_result, dest_reg, reg_write, mem_read, mem_write,
               store_data, redirect, redirect_target,
        input  ready
    );

    modport sink (
        input  valid, alu_result, dest_reg, reg_write, mem_read, mem_write,
               store_data, redirect, redirect_target,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/mdx_decode.sv
// Instruction decoder: opcode and function code to execute controls.
`default_nettype none

module mdx_decode (
    input  wire logic [31:0]   instruction,
    output mdx_pkg::ctrl_t     ctrl
);
    import mdx_pkg::*;

    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rt;
    logic [4:0] rd;

    assign op = instruction[31:26];
    assign fn = instruction[5:0];
    assign rt = instruction[20:16];
    assign rd = instruction[15:11];

    always_comb
    begin
        ctrl.alu_op    = ALU_NONE;
        ctrl.opb_sel   = OPB_REG;
        ctrl.reg_write = 1'b0;
        ctrl.dest_reg  = 5'd0;
        ctrl.mem_read  = 1'b0;
        ctrl.mem_write = 1'b0;
        ctrl.branch_eq = 1'b0;
        ctrl.branch_ne = 1'b0;
        ctrl.jump_abs  = 1'b0;
        ctrl.jump_reg  = 1'b0;

        // An all-zero word is a nop, not sll r0.
        if (instruction != 32'd0)
        begin
            case (op)
                OP_RTYPE:
                begin
                    ctrl.reg_write = 1'b1;
                    ctrl.dest_reg  = rd;
                    case (fn)
                        FN_SLL:          ctrl.alu_op = ALU_SLL;
                        FN_SRL:          ctrl.alu_op = ALU_SRL;
                        FN_ADD, FN_ADDU: ctrl.alu_op = ALU_ADD;
                        FN_SUB, FN_SUBU: ctrl.alu_op = ALU_SUB;
                        FN_AND:          ctrl.alu_op = ALU_AND;
                        FN_OR:           ctrl.alu_op = ALU_OR;
                        FN_NOR:          ctrl.alu_op = ALU_NOR;
                        FN_SLT:          ctrl.alu_op = ALU_SLT;
                        FN_SLTU:         ctrl.alu_op = ALU_SLTU;
                        FN_JR, FN_JALR:
                        begin
                            // jalr links nothing here
                            ctrl.reg_write = 1'b0;
                            ctrl.dest_reg  = 5'd0;
                            ctrl.jump_reg  = 1'b1;
                        end
                        default:
                        begin
                            ctrl.reg_write = 1'b0;
                            ctrl.dest_reg  = 5'd0;
                        end
                    endcase
                end
                OP_J:
                    ctrl.jump_abs = 1'b1;
                OP_JAL:
                begin
                    ctrl.jump_abs  = 1'b1;
                    ctrl.alu_op    = ALU_LINK;
                    ctrl.reg_write = 1'b1;
                    ctrl.dest_reg  = LINK_REG;
                end
                OP_BEQ:
                    ctrl.branch_eq = 1'b1;
                OP_BNE:
                    ctrl.branch_ne = 1'b1;
                OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI:
                begin
                    ctrl.reg_write = 1'b1;
                    ctrl.dest_reg  = rt;
                    case (op)
                        OP_SLTI:
                        begin
                            ctrl.alu_op  = ALU_SLT;
                            ctrl.opb_sel = OPB_SIMM;
                        end
                        OP_SLTIU:
                        begin
                            ctrl.alu_op  = ALU_SLTU;
                            ctrl.opb_sel = OPB_SIMM;
                        end
                        OP_ANDI:
                        begin
                            ctrl.alu_op  = ALU_AND;
                            ctrl.opb_sel = OPB_ZIMM;
                        end
                        OP_ORI:
                        begin
                            ctrl.alu_op  = ALU_OR;
                            ctrl.opb_sel = OPB_ZIMM;
                        end
                        OP_LUI:
                            ctrl.alu_op = ALU_LUI;
                        default:
                        begin
                            ctrl.alu_op  = ALU_ADD;
                            ctrl.opb_sel = OPB_SIMM;
                        end
                    endcase
                end
                OP_LW:
                begin
                    ctrl.alu_op    = ALU_ADD;
                    ctrl.opb_sel   = OPB_SIMM;
                    ctrl.reg_write = 1'b1;
                    ctrl.dest_reg  = rt;
                    ctrl.mem_read  = 1'b1;
                end
                OP_SW:
                begin
                    ctrl.alu_op    = ALU_ADD;
                    ctrl.opb_sel   = OPB_SIMM;
                    ctrl.mem_write = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mdx_alu.sv
// ALU, branch compare and target adders for one decoded instruction.
`default_nettype none

module mdx_alu (
    input  wire mdx_pkg::ctrl_t     ctrl,
    input  wire mdx_pkg::in_item_t  item,
    output wire mdx_pkg::out_item_t result
);
    import mdx_pkg::*;

    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic [31:0] alu_out;
    logic [31:0] branch_target;
    logic [31:0] jump_target;
    logic        taken;
    logic        redirect;
    logic [31:0] target;

    assign a     = item.rs_value;
    assign b     = item.rt_value;
    assign imm   = item.instruction[15:0];
    assign simm  = {{16{imm[15]}}, imm};
    assign shamt = item.instruction[10:6];

    always_comb
    begin
        case (ctrl.opb_sel)
            OPB_SIMM: opb = simm;
            OPB_ZIMM: opb = {16'd0, imm};
            default:  opb = b;
        endcase
    end

    always_comb
    begin
        case (ctrl.alu_op)
            ALU_ADD:  alu_out = a + opb;
            ALU_SUB:  alu_out = a - opb;
            ALU_AND:  alu_out = a & opb;
            ALU_OR:   alu_out = a | opb;
            ALU_NOR:  alu_out = ~(a | opb);
            ALU_SLT:  alu_out = {31'd0, $signed(a) < $signed(opb)};
            ALU_SLTU: alu_out = {31'd0, a < opb};
            ALU_SLL:  alu_out = b << shamt;
            ALU_SRL:  alu_out = b >> shamt;
            ALU_LUI:  alu_out = {imm, 16'd0};
            ALU_LINK: alu_out = item.pc_plus4 + 32'd4;
            default:  alu_out = 32'd0;
        endcase
    end

    assign branch_target = item.pc_plus4 + {simm[29:0], 2'b00};
    assign jump_target   = {item.pc_plus4[31:28], item.instruction[25:0], 2'b00};

    assign taken    = (ctrl.branch_eq && (a == b)) || (ctrl.branch_ne && (a != b));
    assign redirect = taken || ctrl.jump_abs || ctrl.jump_reg;

    always_comb
    begin
        if (ctrl.jump_reg)
            target = a;
        else if (ctrl.jump_abs)
            target = jump_target;
        else
            target = branch_target;
    end

    assign result.alu_result      = alu_out;
    assign result.dest_reg        = ctrl.reg_write ? ctrl.dest_reg : 5'd0;
    assign result.reg_write       = ctrl.reg_write;
    assign result.mem_read        = ctrl.mem_read;
    assign result.mem_write       = ctrl.mem_write;
    assign result.store_data      = ctrl.mem_write ? b : 32'd0;
    assign result.redirect        = redirect;
    assign result.redirect_target = redirect ? target : 32'd0;

endmodule

`default_nettype wire

FILE: rtl/mips_decode_execute.sv
// Top level of the MIPS32 decode and execute stage.
`default_nettype none
`include "mips_decode_execute_defines.svh"

// MIPS32 decode and execute stage. Each instruction transaction (word, pc+4
// and forwarded rs/rt values) is captured in an input register, decoded and
// executed by one pass of combinational logic, and held in a result register
// until the result transaction is taken. The stage accepts one instruction
// every clock cycle unless a stalled result backs up both register stages;
// a result is offered once it has passed the input and result registers.
// in_ch.ready depends combinationally on out_ch.ready through the stall
// logic of both register stages. Results come out in order: ALU value,
// effective address or link address, destination, write and memory controls,
// store data and the branch/jump redirect.
module mips_decode_execute (
    input  wire logic clk,
    input  wire logic rst_n,
    mdx_in_if.sink    in_ch,
    mdx_out_if.source out_ch
);
    import mdx_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      in_valid_next;
    logic      out_valid_next;
    logic      out_free;
    logic      in_free;
    logic      advance;
    ctrl_t     ctrl;
    out_item_t result;

    // A stage takes new data when empty or when its content leaves this cycle.
    assign out_free = !out_valid_reg || out_ch.ready;
    assign advance  = in_valid_reg && out_free;
    assign in_free  = !in_valid_reg || out_free;

    assign in_ch.ready = in_free;

    assign in_valid_next  = in_ch.valid || (in_valid_reg && !out_free);
    assign out_valid_next = advance || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_free)
        begin
            in_item_reg.instruction <= in_ch.instruction;
            in_item_reg.pc_plus4    <= in_ch.pc_plus4;
            in_item_reg.rs_value    <= in_ch.rs_value;
            in_item_reg.rt_value    <= in_ch.rt_value;
        end
        if (advance)
            out_item_reg <= result;
    end

    mdx_decode u_decode (
        .instruction (in_item_reg.instruction),
        .ctrl        (ctrl)
    );

    mdx_alu u_alu (
        .ctrl   (ctrl),
        .item   (in_item_reg),
        .result (result)
    );

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.alu_result      = out_item_reg.alu_result;
    assign out_ch.dest_reg        = out_item_reg.dest_reg;
    assign out_ch.reg_write       = out_item_reg.reg_write;
    assign out_ch.mem_read        = out_item_reg.mem_read;
    assign out_ch.mem_write       = out_item_reg.mem_write;
    assign out_ch.store_data      = out_item_reg.store_data;
    assign out_ch.redirect        = out_item_reg.redirect;
    assign out_ch.redirect_target = out_item_reg.redirect_target;

    `MDX_ASSERT(a_out_from_input, clk, rst_n, $rose(out_valid_reg) |-> $past(in_valid_reg), "result transaction without a captured instruction")
    `MDX_ASSERT(a_hold_unaccepted, clk, rst_n, (in_valid_reg && !out_free) |=> in_valid_reg, "pending instruction dropped while result stalled")
    `MDX_ASSERT(a_no_write_dest, clk, rst_n, (out_valid_reg && !out_item_reg.reg_write) |-> (out_item_reg.dest_reg == 5'd0), "destination reported without a register write")
    `MDX_ASSERT(a_mem_excl, clk, rst_n, out_valid_reg |-> !(out_item_reg.mem_read && out_item_reg.mem_write), "load and store flagged together")
    `MDX_ASSERT(a_target_idle, clk, rst_n, (out_valid_reg && !out_item_reg.redirect) |-> (out_item_reg.redirect_target == 32'd0), "redirect target set without redirect")

endmodule

`default_nettype wire

FILE: verif/tb_mips_decode_execute.sv
// Testbench for the MIPS32 decode and execute stage: directed and random instruction traffic.
`default_nettype none

module tb_mips_decode_execute;
    timeunit 1ns;
    timeprecision 1ps;

    import mdx_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int MAX_IDLE     = 15;
    localparam int SETTLE_CYC   = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    logic clk;
    logic rst_n;

    mdx_in_if  in_ch ();
    mdx_out_if out_ch ();

    mips_decode_execute i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    out_item_t exec_q[$];
    int        mismatch_cnt;
    int        cycle_cnt;
    bit        gaps_on;
    bit        stalls_on;
    int        hold_len;

    always #CLK_HALF clk = ~clk;

    // Expected result of one instruction transaction.
    function automatic out_item_t exec_model(in_item_t it);
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [15:0] imm;
        logic [31:0] simm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        logic [31:0] btgt;
        logic [31:0] jtgt;
        logic        wr;
        out_item_t   o;
        o    = '0;
        op   = it.instruction[31:26];
        rt   = it.instruction[20:16];
        rd   = it.instruction[15:11];
        sh   = it.instruction[10:6];
        fn   = it.instruction[5:0];
        imm  = it.instruction[15:0];
        simm = {{16{imm[15]}}, imm};
        a    = it.rs_value;
        b    = it.rt_value;
        btgt = it.pc_plus4 + (simm << 2);
        jtgt = {it.pc_plus4[31:28], it.instruction[25:0], 2'b00};
        res  = '0;
        wr   = 1'b0;
        if (it.instruction == 32'h0)
            return o;
        case (op)
            OP_RTYPE:
            begin
                wr = 1'b1;
                case (fn)
                    FN_SLL:           res = b << sh;
                    FN_SRL:           res = b >> sh;
                    FN_ADD, FN_ADDU:  res = a + b;
                    FN_SUB, FN_SUBU:  res = a - b;
                    FN_AND:           res = a & b;
                    FN_OR:            res = a | b;
                    FN_NOR:           res = ~(a | b);
                    FN_SLT:           res = {31'b0, $signed(a) < $signed(b)};
                    FN_SLTU:          res = {31'b0, a < b};
                    FN_JR, FN_JALR:
                    begin
                        wr = 1'b0;
                        o.redirect        = 1'b1;
                        o.redirect_target = a;
                    end
                    default:          wr = 1'b0;
                endcase
                if (wr)
                begin
                    o.alu_result = res;
                    o.dest_reg   = rd;
                    o.reg_write  = 1'b1;
                end
                return o;
            end
            OP_J:
            begin
                o.redirect        = 1'b1;
                o.redirect_target = jtgt;
                return o;
            end
            OP_JAL:
            begin
                o.alu_result      = it.pc_plus4 + 32'd4;
                o.dest_reg        = LINK_REG;
                o.reg_write       = 1'b1;
                o.redirect        = 1'b1;
                o.redirect_target = jtgt;
                return o;
            end
            OP_BEQ, OP_BNE:
            begin
                if ((a == b) == (op == OP_BEQ))
                begin
                    o.redirect        = 1'b1;
                    o.redirect_target = btgt;
                end
                return o;
            end
            OP_LW:
            begin
                o.alu_result = a + simm;
                o.dest_reg   = rt;
                o.reg_write  = 1'b1;
                o.mem_read   = 1'b1;
                return o;
            end
            OP_SW:
            begin
                o.alu_result = a + simm;
                o.mem_write  = 1'b1;
                o.store_data = b;
                return o;
            end
            OP_ADDI, OP_ADDIU:  begin res = a + simm;                        wr = 1'b1; end
            OP_SLTI:            begin res = {31'b0, $signed(a) < $signed(simm)}; wr = 1'b1; end
            OP_SLTIU:           begin res = {31'b0, a < simm};               wr = 1'b1; end
            OP_ANDI:            begin res = a & {16'h0, imm};                wr = 1'b1; end
            OP_ORI:             begin res = a | {16'h0, imm};                wr = 1'b1; end
            OP_LUI:             begin res = {imm, 16'h0};                    wr = 1'b1; end
            default:            wr = 1'b0;
        endcase
        if (wr)
        begin
            o.alu_result = res;
            o.dest_reg   = rt;
            o.reg_write  = 1'b1;
        end
        return o;
    endfunction

    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic in_item_t mk(logic [31:0] word, logic [31:0] pc4,
                                    logic [31:0] a, logic [31:0] b);
        in_item_t it;
        it.instruction = word;
        it.pc_plus4    = pc4;
        it.rs_value    = a;
        it.rt_value    = b;
        return it;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            4:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        int          sel;
        logic [25:0] body;
        logic [5:0]  code;
        sel  = $urandom_range(0, 99);
        body = 26'($urandom());
        if (sel < 3)
            return 32'h0;
        if (sel < 8)
            return $urandom();
        if (sel < 45)
        begin
            case ($urandom_range(0, 13))
                0:       code = FN_SLL;
                1:       code = FN_SRL;
                2:       code = FN_JR;
                3:       code = FN_JALR;
                4:       code = FN_ADD;
                5:       code = FN_ADDU;
                6:       code = FN_SUB;
                7:       code = FN_SUBU;
                8:       code = FN_AND;
                9:       code = FN_OR;
                10:      code = FN_NOR;
                11:      code = FN_SLT;
                12:      code = FN_SLTU;
                default: code = 6'($urandom_range(0, 63));
            endcase
            return {OP_RTYPE, body[25:6], code};
        end
        case ($urandom_range(0, 13))
            0:       code = OP_J;
            1:       code = OP_JAL;
            2:       code = OP_BEQ;
            3:       code = OP_BNE;
            4:       code = OP_ADDI;
            5:       code = OP_ADDIU;
            6:       code = OP_SLTI;
            7:       code = OP_SLTIU;
            8:       code = OP_ANDI;
            9:       code = OP_ORI;
            10:      code = OP_LUI;
            11:      code = OP_LW;
            12:      code = OP_SW;
            default: code = 6'($urandom_range(0, 63));
        endcase
        return {code, body};
    endfunction

    function automatic in_item_t rand_instr();
        in_item_t it;
        it = mk(rand_word(), $urandom(), rand_operand(), rand_operand());
        // Bias branches toward equal operands so both outcomes show up.
        if ((it.instruction[31:26] == OP_BEQ || it.instruction[31:26] == OP_BNE) &&
            $urandom_range(0, 1) == 1)
            it.rt_value = it.rs_value;
        return it;
    endfunction

    // Offer one instruction; return at the edge where it is taken.
    task automatic send_instr(in_item_t it);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.instruction <= it.instruction;
        in_ch.pc_plus4    <= it.pc_plus4;
        in_ch.rs_value    <= it.rs_value;
        in_ch.rt_value    <= it.rt_value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        exec_q.push_back(exec_model(it));
    endtask

    task automatic send_random(int count);
        repeat (count) send_instr(rand_instr());
    endtask

    // Drop valid, wait until every expected result is back, then let the pipe settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (exec_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic test_directed();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_instr(mk(32'h0, 32'hffff_fffc, 32'hffff_ffff, 32'hffff_ffff));
        send_instr(mk(enc_r(FN_SLL, 5'd0, 5'd3, 5'd5, 5'd31), 32'h4, 32'h0, 32'h1));
        send_instr(mk(enc_r(FN_SRL, 5'd0, 5'd3, 5'd6, 5'd31), 32'h8, 32'h0, 32'h8000_0000));
        send_instr(mk(enc_r(FN_ADD, 5'd1, 5'd2, 5'd7, 5'd0), 32'hc, 32'h7fff_ffff, 32'h1));
        send_instr(mk(enc_r(FN_ADDU, 5'd1, 5'd2, 5'd8, 5'd0), 32'h10, 32'hffff_ffff, 32'h1));
        send_instr(mk(enc_r(FN_SUB, 5'd1, 5'd2, 5'd9, 5'd0), 32'h14, 32'h0, 32'h1));
        send_instr(mk(enc_r(FN_SUBU, 5'd1, 5'd2, 5'd10, 5'd0), 32'h18,
                      32'h8000_0000, 32'h7fff_ffff));
        send_instr(mk(enc_r(FN_AND, 5'd1, 5'd2, 5'd11, 5'd0), 32'h1c,
                      32'hffff_ffff, 32'h5a5a_a5a5));
        send_instr(mk(enc_r(FN_OR, 5'd1, 5'd2, 5'd12, 5'd0), 32'h20,
                      32'h0f0f_0000, 32'h0000_f0f0));
        send_instr(mk(enc_r(FN_NOR, 5'd1, 5'd2, 5'd13, 5'd0), 32'h24, 32'h0, 32'h0));
        send_instr(mk(enc_r(FN_SLT, 5'd1, 5'd2, 5'd14, 5'd0), 32'h28, 32'h8000_0000, 32'h1));
        send_instr(mk(enc_r(FN_SLTU, 5'd1, 5'd2, 5'd15, 5'd0), 32'h2c, 32'h8000_0000, 32'h1));
        send_instr(mk(enc_r(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 32'h30, 32'hdead_beef, 32'h0));
        send_instr(mk(enc_r(FN_JALR, 5'd4, 5'd0, 5'd31, 5'd0), 32'h34, 32'hffff_fffc, 32'h0));
        send_instr(mk(enc_r(6'h3f, 5'd1, 5'd2, 5'd3, 5'd0), 32'h38, 32'h1, 32'h2));
        send_instr(mk({OP_J, 26'h3ff_ffff}, 32'hf000_0000, 32'h0, 32'h0));
        send_instr(mk({OP_JAL, 26'h000_0001}, 32'hffff_fffc, 32'h0, 32'h0));
        send_instr(mk(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h8000), 32'h0000_0004,
                      32'h1234_5678, 32'h1234_5678));
        send_instr(mk(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h0010), 32'h100, 32'h1, 32'h2));
        send_instr(mk(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7fff), 32'hffff_fff0, 32'h0, 32'h1));
        send_instr(mk(enc_i(OP_BNE, 5'd1, 5'd2, 16'h0004), 32'h200, 32'h55, 32'h55));
        send_instr(mk(enc_i(OP_ADDI, 5'd1, 5'd2, 16'h8000), 32'h204, 32'h0, 32'h0));
        // Write to register zero is reported as is.
        send_instr(mk(enc_i(OP_ADDIU, 5'd1, 5'd0, 16'hffff), 32'h208, 32'h7fff_ffff, 32'h0));
        send_instr(mk(enc_i(OP_SLTI, 5'd1, 5'd2, 16'h0001), 32'h20c, 32'hffff_ffff, 32'h0));
        send_instr(mk(enc_i(OP_SLTIU, 5'd1, 5'd2, 16'hffff), 32'h210, 32'h1, 32'h0));
        send_instr(mk(enc_i(OP_ANDI, 5'd1, 5'd2, 16'hffff), 32'h214, 32'hffff_ffff, 32'h0));
        send_instr(mk(enc_i(OP_ORI, 5'd1, 5'd2, 16'h8001), 32'h218, 32'hffff_0000, 32'h0));
        send_instr(mk(enc_i(OP_LUI, 5'd0, 5'd31, 16'hffff), 32'h21c, 32'h1234_5678, 32'h0));
        send_instr(mk(enc_i(OP_LW, 5'd1, 5'd2, 16'hfffc), 32'h220, 32'h0000_0000, 32'h0));
        send_instr(mk(enc_i(OP_SW, 5'd1, 5'd2, 16'h7ffc), 32'h224, 32'hffff_fff0, 32'hcafe_f00d));
        send_instr(mk({6'h3f, 26'h3ff_ffff}, 32'h228, 32'hffff_ffff, 32'hffff_ffff));
        drain_results();
    endtask

    // Random traffic in phases with every mix of source and sink idling.
    task automatic test_random_mix();
        for (int ph = 0; ph < 8; ph++)
        begin
            gaps_on   = ph[0];
            stalls_on = ph[1] ^ ph[2];
            send_random(100);
        end
        drain_results();
    endtask

    // Hold the sink off while the source streams, so the stage backs up.
    task automatic test_backpressure();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        hold_len  = 300;
        send_random(150);
        drain_results();
    endtask

    task automatic test_burst_pause();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_random(60);
        drain_results();
        send_random(60);
        drain_results();
    endtask

    task automatic test_streaming();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_random(200);
        drain_results();
    endtask

    // Result sink: random stall before each transaction, or a long hold on request.
    initial
    begin
        int stall;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_len != 0)
            begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (exec_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: alu=%h dest=%0d",
                             $realtime, out_ch.alu_result, out_ch.dest_reg);
            end
            else
            begin
                want = exec_q.pop_front();
                if (out_ch.alu_result      !== want.alu_result ||
                    out_ch.dest_reg        !== want.dest_reg ||
                    out_ch.reg_write       !== want.reg_write ||
                    out_ch.mem_read        !== want.mem_read ||
                    out_ch.mem_write       !== want.mem_write ||
                    out_ch.store_data      !== want.store_data ||
                    out_ch.redirect        !== want.redirect ||
                    out_ch.redirect_target !== want.redirect_target)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                    begin
                        $display({"%0t: mismatch exp alu=%h dst=%0d wr=%b rd=%b wm=%b",
                                  " sd=%h rdr=%b tgt=%h"},
                                 $realtime, want.alu_result, want.dest_reg, want.reg_write,
                                 want.mem_read, want.mem_write, want.store_data,
                                 want.redirect, want.redirect_target);
                        $display({"%0t:          got alu=%h dst=%0d wr=%b rd=%b wm=%b",
                                  " sd=%h rdr=%b tgt=%h"},
                                 $realtime, out_ch.alu_result, out_ch.dest_reg,
                                 out_ch.reg_write, out_ch.mem_read, out_ch.mem_write,
                                 out_ch.store_data, out_ch.redirect,
                                 out_ch.redirect_target);
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        mismatch_cnt      = 0;
        gaps_on           = 1'b0;
        stalls_on         = 1'b0;
        hold_len          = 0;
        in_ch.valid       = 1'b0;
        in_ch.instruction = '0;
        in_ch.pc_plus4    = '0;
        in_ch.rs_value    = '0;
        in_ch.rt_value    = '0;
        out_ch.ready      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix();
        test_backpressure();
        test_burst_pause();
        test_streaming();

        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
